/* design/mlp_2_2_2_1_inference_assert.svh */
// assertion macros shared by the checkers of the perceptron block
`ifndef MLP_2_2_2_1_INFERENCE_ASSERT_SVH
`define MLP_2_2_2_1_INFERENCE_ASSERT_SVH

// condition holds at every edge out of reset
`define MLP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds at the edge after the antecedent
`define MLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/mlp_pkg.sv */
`timescale 1ns / 1ps
package mlp_pkg;

  typedef longint unsigned u64_t;

  localparam int DATA_W        = 16;
  localparam int X_W           = DATA_W + 1;
  localparam int NUM_STAGES    = 8;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 8;
  localparam int SIG_DEPTH_DEF = 256;

  localparam logic [CFG_IDX_W-1:0] REG_L1_WEIGHTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L1_BIAS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L2_WEIGHTS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_L2_BIAS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_TERMS  = 3'd4;

  typedef struct packed {
    logic prod;
    logic sum;
    logic act;
  } stage_en_t;

  // restoring long division, only evaluated while the table is elaborated
  function automatic u64_t udiv_u64(input u64_t n, input u64_t d);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] nb;
    q  = '0;
    r  = '0;
    nb = n;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], nb[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // table entry k: 2^frac / (1 + exp(zk)) at the bin center, exp from a
  // series for exp(-|z|/16) and four squarings, all in Q.32
  function automatic logic [DATA_W-1:0] act_entry(input int k, input int depth,
                                                  input int frac);
    u64_t one;
    u64_t s;
    u64_t term;
    u64_t e;
    u64_t mag;
    u64_t den;
    u64_t num;
    u64_t y;
    u64_t top;
    longint sum;
    longint zq;
    one  = u64_t'(1) << 32;
    zq   = longint'(udiv_u64(u64_t'(2 * k + 1) << 35, u64_t'(depth)))
           - (longint'(1) << 35);
    mag  = (zq < 0) ? u64_t'(-zq) : u64_t'(zq);
    s    = mag >> 4;
    term = one;
    sum  = longint'(one);
    for (int i = 1; i <= 14; i++) begin
      term = udiv_u64((term * s) >> 32, u64_t'(i));
      if ((i & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = u64_t'(sum);
    if (e > one) begin
      e = one;
    end
    for (int r = 0; r < 4; r++) begin
      if (e < one) begin
        e = (e * e) >> 32;
      end
    end
    den = one + e;
    num = (zq >= 0) ? (e << frac) : (one << frac);
    y   = udiv_u64(num + (den >> 1), den);
    top = (u64_t'(1) << frac) - 1;
    if (y > top) begin
      y = top;
    end
    return y[DATA_W-1:0];
  endfunction

endpackage

/* design/mlp_in_if.sv */
`timescale 1ns / 1ps
interface mlp_in_if;
  import mlp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] feature_a;
  logic signed [DATA_W-1:0] feature_b;

  modport source (output valid, output feature_a, output feature_b, input ready);
  modport sink   (input valid, input feature_a, input feature_b, output ready);
endinterface

/* design/mlp_out_if.sv */
`timescale 1ns / 1ps
interface mlp_out_if;
  import mlp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] net_value;

  modport source (output valid, output net_value, input ready);
  modport sink   (input valid, input net_value, output ready);
endinterface

/* design/mlp_act.sv */
`timescale 1ns / 1ps
module mlp_act #(
  parameter int FRAC_BITS = mlp_pkg::FRAC_BITS_DEF,
  parameter int DEPTH     = mlp_pkg::SIG_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [mlp_pkg::DATA_W-1:0] z,
  output logic        [FRAC_BITS-1:0]      a_r
);
  import mlp_pkg::*;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int OFF_W  = DATA_W + 2;
  localparam int PROD_W = OFF_W - 1 + IDX_W + 1;

  logic        [FRAC_BITS-1:0] tbl [DEPTH];
  logic signed [OFF_W-1:0]     off;
  logic        [PROD_W-1:0]    prod;
  logic        [PROD_W-1:0]    bin;
  logic        [IDX_W-1:0]     idx;
  logic        [FRAC_BITS-1:0] a_nxt;

  for (genvar k = 0; k < DEPTH; k++) begin : g_tbl
    localparam logic [DATA_W-1:0] ENTRY = act_entry(k, DEPTH, FRAC_BITS);
    assign tbl[k] = ENTRY[FRAC_BITS-1:0];
  end

  // bin index over z in [-8, 8)
  always_comb begin
    off  = OFF_W'(z) + OFF_W'(8 << FRAC_BITS);
    prod = PROD_W'(off[OFF_W-2:0]) * PROD_W'(DEPTH);
    bin  = prod >> (FRAC_BITS + 4);
    if (off < 0) begin
      idx = '0;
    end else if (bin > PROD_W'(DEPTH - 1)) begin
      idx = IDX_W'(DEPTH - 1);
    end else begin
      idx = bin[IDX_W-1:0];
    end
    a_nxt = tbl[idx];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
    end
  end
endmodule

/* design/mlp_neuron.sv */
`timescale 1ns / 1ps
module mlp_neuron #(
  parameter int FRAC_BITS = mlp_pkg::FRAC_BITS_DEF,
  parameter int DEPTH     = mlp_pkg::SIG_DEPTH_DEF,
  parameter bit ACT       = 1'b1
) (
  input  logic                              clk,
  input  mlp_pkg::stage_en_t                en,
  input  logic signed [mlp_pkg::X_W-1:0]    x0,
  input  logic signed [mlp_pkg::X_W-1:0]    x1,
  input  logic signed [mlp_pkg::DATA_W-1:0] w0,
  input  logic signed [mlp_pkg::DATA_W-1:0] w1,
  input  logic signed [mlp_pkg::DATA_W-1:0] bias,
  output logic signed [mlp_pkg::DATA_W-1:0] y
);
  import mlp_pkg::*;

  localparam int PROD_W = X_W + DATA_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int Z_W    = SUM_W + 1;
  localparam logic signed [Z_W-1:0] SAT_HI = Z_W'(2 ** (DATA_W - 1) - 1);
  localparam logic signed [Z_W-1:0] SAT_LO = -Z_W'(2 ** (DATA_W - 1));

  logic signed [PROD_W-1:0] p0_r, p1_r;
  logic signed [SUM_W-1:0]  acc;
  logic signed [Z_W-1:0]    zw;
  logic signed [DATA_W-1:0] z_nxt, z_r;

  always_ff @(posedge clk) begin
    if (en.prod) begin
      p0_r <= PROD_W'(x0) * PROD_W'(w0);
      p1_r <= PROD_W'(x1) * PROD_W'(w1);
    end
  end

  // arithmetic shift floors toward minus infinity
  always_comb begin
    acc = (SUM_W'(p0_r) + SUM_W'(p1_r)) >>> FRAC_BITS;
    zw  = Z_W'(acc) - Z_W'(bias);
    if (zw > SAT_HI) begin
      z_nxt = SAT_HI[DATA_W-1:0];
    end else if (zw < SAT_LO) begin
      z_nxt = SAT_LO[DATA_W-1:0];
    end else begin
      z_nxt = zw[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      z_r <= z_nxt;
    end
  end

  if (ACT) begin : g_act
    logic [FRAC_BITS-1:0] a;
    mlp_act #(.FRAC_BITS(FRAC_BITS), .DEPTH(DEPTH)) u_act (
      .clk (clk),
      .en  (en.act),
      .z   (z_r),
      .a_r (a)
    );
    assign y = DATA_W'(a);
  end else begin : g_lin
    assign y = z_r;
  end
endmodule

/* design/mlp_2_2_2_1_inference.sv */
`timescale 1ns / 1ps
// 2-2-2-1 perceptron, forward pass in signed Q8.8 fixed point
// in_ch carries feature_a and feature_b; out_ch carries net_value; both use
// valid/ready and move an item at an edge where both are high
// cfg_we/cfg_index/cfg_data write the weight and bias registers, one a cycle;
// write them only while no item is in flight
// each hidden layer runs its two neurons as parallel lanes (multiply stage,
// sum and saturate stage, table sigmoid stage); the output neuron merges the
// second layer lanes and its sum register is the output register
// an accepted item passes the eight stages in order: the multiply, sum and
// sigmoid stages of both hidden layers, then the output multiply and sum stages
// throughput: one item per cycle while out_ch.ready is high
// on a receiver stall, the stages fill in order behind the waiting result and
// in_ch.ready drops only when all eight stages hold an item
// reset clears all stage valids and the weight and bias registers to zero
module mlp_2_2_2_1_inference #(
  parameter int FRAC_BITS           = mlp_pkg::FRAC_BITS_DEF,
  parameter int SIGMOID_TABLE_DEPTH = mlp_pkg::SIG_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mlp_in_if.sink                          in_ch,
  mlp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [mlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlp_pkg::CFG_W-1:0]       cfg_data
);
  import mlp_pkg::*;

  logic [63:0] l1_w_r;
  logic [31:0] l1_b_r;
  logic [63:0] l2_w_r;
  logic [31:0] l2_b_r;
  logic [47:0] out_t_r;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] en;

  stage_en_t l1_en, l2_en, o_en;

  logic signed [X_W-1:0]    xa, xb;
  logic signed [DATA_W-1:0] h1 [2];
  logic signed [DATA_W-1:0] h2 [2];
  logic signed [DATA_W-1:0] y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_w_r  <= '0;
      l1_b_r  <= '0;
      l2_w_r  <= '0;
      l2_b_r  <= '0;
      out_t_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_L1_WEIGHTS: l1_w_r  <= cfg_data;
        REG_L1_BIAS:    l1_b_r  <= cfg_data[31:0];
        REG_L2_WEIGHTS: l2_w_r  <= cfg_data;
        REG_L2_BIAS:    l2_b_r  <= cfg_data[31:0];
        REG_OUT_TERMS:  out_t_r <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its item moves on
  assign en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ch.ready;
  for (genvar s = 0; s < NUM_STAGES - 1; s++) begin : g_en
    assign en[s] = !v_r[s] || en[s+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  assign in_ch.ready      = en[0];
  assign out_ch.valid     = v_r[NUM_STAGES-1];
  assign out_ch.net_value = y;

  assign l1_en = '{prod: en[0], sum: en[1], act: en[2]};
  assign l2_en = '{prod: en[3], sum: en[4], act: en[5]};
  assign o_en  = '{prod: en[6], sum: en[7], act: 1'b0};

  assign xa = X_W'(in_ch.feature_a);
  assign xb = X_W'(in_ch.feature_b);

  for (genvar j = 0; j < 2; j++) begin : g_lane
    mlp_neuron #(.FRAC_BITS(FRAC_BITS), .DEPTH(SIGMOID_TABLE_DEPTH), .ACT(1'b1)) u_l1 (
      .clk  (clk),
      .en   (l1_en),
      .x0   (xa),
      .x1   (xb),
      .w0   (l1_w_r[16*j +: 16]),
      .w1   (l1_w_r[16*(2+j) +: 16]),
      .bias (l1_b_r[16*j +: 16]),
      .y    (h1[j])
    );
    mlp_neuron #(.FRAC_BITS(FRAC_BITS), .DEPTH(SIGMOID_TABLE_DEPTH), .ACT(1'b1)) u_l2 (
      .clk  (clk),
      .en   (l2_en),
      .x0   (X_W'(h1[0])),
      .x1   (X_W'(h1[1])),
      .w0   (l2_w_r[16*j +: 16]),
      .w1   (l2_w_r[16*(2+j) +: 16]),
      .bias (l2_b_r[16*j +: 16]),
      .y    (h2[j])
    );
  end

  // merge: linear output neuron over the second layer lanes
  mlp_neuron #(.FRAC_BITS(FRAC_BITS), .DEPTH(SIGMOID_TABLE_DEPTH), .ACT(1'b0)) u_out (
    .clk  (clk),
    .en   (o_en),
    .x0   (X_W'(h2[0])),
    .x1   (X_W'(h2[1])),
    .w0   (out_t_r[15:0]),
    .w1   (out_t_r[31:16]),
    .bias (out_t_r[47:32]),
    .y    (y)
  );
endmodule

/* design/mlp_chk.sv */
`timescale 1ns / 1ps
`include "mlp_2_2_2_1_inference_assert.svh"
module mlp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] net_value
);
  // a held result keeps its value
  `MLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(net_value), "held item changed")
  // input backpressure only comes from a stalled result
  `MLP_ASSERT_ALWAYS(a_ready_stall, in_ready || (out_valid && !out_ready), "input stalled without output stall")
  // an empty output register never blocks the input
  `MLP_ASSERT_ALWAYS(a_empty_ready, out_valid || in_ready, "input blocked while output empty")
  // nothing comes out in the cycle after reset
  `MLP_ASSERT_ALWAYS(a_reset_empty, !$past(!rst_n) || !out_valid, "item shown right after reset")
endmodule

bind mlp_2_2_2_1_inference mlp_chk u_mlp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .net_value (out_ch.net_value)
);
